// ===== sv/range_set_filter_core_assert.svh =====
// Assertion macros used by the range set filter core.
`ifndef RANGE_SET_FILTER_CORE_ASSERT_SVH
`define RANGE_SET_FILTER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RSF_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("range set filter check failed");

// next-cycle implication
`define RSF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("range set filter check failed");

`endif

// ===== sv/rsf_pkg.sv =====
// Shared constants and types of the range set filter.
package rsf_pkg;

    localparam int MAX_RANGES = 64;
    localparam int CNTW       = $clog2(MAX_RANGES + 1);

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // token that walks the cell row; lo doubles as the query value
    typedef struct packed {
        logic        vld;
        logic        is_query;
        logic [31:0] lo;
        logic [31:0] hi;
        logic        ovf;
        logic        moved;
        logic        hit;
        logic        next_ok;
        logic [31:0] next;
        logic        first_ok;
        logic [31:0] first;
    } rsf_token_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] next_value;
        logic        next_found;
        logic [31:0] first_value;
        logic        first_found;
        logic        added;
        logic        table_full;
    } rsf_result_t;

endpackage

// ===== sv/rsf_req_if.sv =====
// Request channel: valid/ready handshake with the request payload.
interface rsf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] value;
    logic [31:0] range_end;

    modport source (output valid, output req_type, output value, output range_end,
                    input ready);
    modport sink   (input valid, input req_type, input value, input range_end,
                    output ready);
endinterface

// ===== sv/rsf_rsp_if.sv =====
// Response channel: valid/ready handshake with the result payload.
interface rsf_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] next_value;
    logic        next_found;
    logic [31:0] first_value;
    logic        first_found;
    logic        added;
    logic        table_full;

    modport source (output valid, output hit, output next_value, output next_found,
                    output first_value, output first_found, output added,
                    output table_full, input ready);
    modport sink   (input valid, input hit, input next_value, input next_found,
                    input first_value, input first_found, input added,
                    input table_full, output ready);
endinterface

// ===== sv/rsf_cell.sv =====
// One table entry: holds a range and updates the passing token against it.
module rsf_cell import rsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rsf_token_t  tok_in,
    input  logic        ent_valid,
    input  logic        wr_en,
    input  logic [31:0] wr_start,
    input  logic [31:0] wr_end,
    output rsf_token_t  tok_out
);

    logic [31:0] start_reg;
    logic [31:0] end_reg;
    rsf_token_t  tok_reg;
    rsf_token_t  tok_next;
    logic        lo_in;
    logic        hi_in;
    logic        has_cand;
    logic [31:0] cand;

    always_comb
    begin
        tok_next = tok_in;
        lo_in    = (start_reg <= tok_in.lo) && (tok_in.lo <= end_reg);
        hi_in    = (start_reg <= tok_in.hi) && (tok_in.hi <= end_reg);
        has_cand = 1'b0;
        cand     = start_reg;
        if (tok_in.lo < start_reg)
        begin
            has_cand = 1'b1;
        end
        else if (tok_in.lo < end_reg)
        begin
            has_cand = 1'b1;
            cand     = tok_in.lo + 32'd1;
        end
        if (tok_in.vld && ent_valid)
        begin
            if (tok_in.is_query)
            begin
                if (lo_in)
                    tok_next.hit = 1'b1;
                if (has_cand && (!tok_in.next_ok || cand < tok_in.next))
                begin
                    tok_next.next    = cand;
                    tok_next.next_ok = 1'b1;
                end
                if (!tok_in.first_ok || start_reg < tok_in.first)
                begin
                    tok_next.first    = start_reg;
                    tok_next.first_ok = 1'b1;
                end
            end
            else
            begin
                // past either edge of the value space the range is empty
                if (lo_in)
                begin
                    tok_next.moved = 1'b1;
                    if (end_reg == 32'hFFFF_FFFF)
                        tok_next.ovf = 1'b1;
                    else
                        tok_next.lo = end_reg + 32'd1;
                end
                if (hi_in)
                begin
                    tok_next.moved = 1'b1;
                    if (start_reg == 32'd0)
                        tok_next.ovf = 1'b1;
                    else
                        tok_next.hi = start_reg - 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_reg <= wr_start;
            end_reg   <= wr_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

// ===== sv/range_set_filter_core.sv =====
// Range set filter: row of entry cells walked by one token per request.
// Query: one pass of the token over the cell row; clear and no-op skip the row.
// Add: one or more trim passes over the cell row, until the range stops moving.
// One request in flight; the next is taken once the result sits in the output register.
// Reset empties the table (entry count to zero); entry contents are not cleared.
module range_set_filter_core import rsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rsf_req_if.sink   req,
    rsf_rsp_if.source rsp
);
    `include "range_set_filter_core_assert.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNTW-1:0]  count_reg, count_next;
    rsf_result_t      res_reg, res_next;
    rsf_result_t      out_reg, out_next;
    logic             out_vld_reg, out_vld_next;

    rsf_token_t       tok_head;
    rsf_token_t       tok_chain [0:MAX_RANGES-1];
    rsf_token_t       tok_last;
    logic [MAX_RANGES-1:0] tok_vld_vec;
    logic [MAX_RANGES-1:0] ent_vld;
    logic [MAX_RANGES-1:0] wr_en;
    logic             wr_do;
    logic             accept;
    logic             out_free;
    logic             last_nonempty;

    genvar k;
    generate
        for (k = 0; k < MAX_RANGES; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                rsf_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .tok_in    (tok_head),
                    .ent_valid (ent_vld[k]),
                    .wr_en     (wr_en[k]),
                    .wr_start  (tok_last.lo),
                    .wr_end    (tok_last.hi),
                    .tok_out   (tok_chain[k])
                );
            end
            else
            begin : g_body
                rsf_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .tok_in    (tok_chain[k-1]),
                    .ent_valid (ent_vld[k]),
                    .wr_en     (wr_en[k]),
                    .wr_start  (tok_last.lo),
                    .wr_end    (tok_last.hi),
                    .tok_out   (tok_chain[k])
                );
            end
            assign ent_vld[k]     = CNTW'(k) < count_reg;
            assign wr_en[k]       = wr_do && (count_reg == CNTW'(k));
            assign tok_vld_vec[k] = tok_chain[k].vld;
        end
    endgenerate

    assign tok_last      = tok_chain[MAX_RANGES-1];
    assign last_nonempty = !tok_last.ovf && (tok_last.lo <= tok_last.hi);
    assign req.ready     = (state_reg == ST_IDLE);
    assign accept        = req.valid && req.ready;
    assign out_free      = !out_vld_reg || rsp.ready;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !rsp.ready;
        tok_head     = '0;
        wr_do        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    state_next = ST_HOLD;
                    case (req.req_type)
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        REQ_ADD:
                        begin
                            if (req.value <= req.range_end)
                            begin
                                tok_head.vld = 1'b1;
                                tok_head.lo  = req.value;
                                tok_head.hi  = req.range_end;
                                state_next   = ST_RUN;
                            end
                        end
                        REQ_QUERY:
                        begin
                            tok_head.vld      = 1'b1;
                            tok_head.is_query = 1'b1;
                            tok_head.lo       = req.value;
                            state_next        = ST_RUN;
                        end
                        default:
                        begin
                            state_next = ST_HOLD;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (tok_last.vld)
                begin
                    if (tok_last.is_query)
                    begin
                        res_next.hit         = tok_last.hit;
                        res_next.next_found  = tok_last.next_ok;
                        res_next.next_value  = tok_last.next_ok ? tok_last.next : 32'd0;
                        res_next.first_found = tok_last.first_ok;
                        res_next.first_value = tok_last.first_ok ? tok_last.first : 32'd0;
                        state_next           = ST_HOLD;
                    end
                    else if (tok_last.moved && last_nonempty)
                    begin
                        // another pass until the range stops moving
                        tok_head       = tok_last;
                        tok_head.moved = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                        if (last_nonempty)
                        begin
                            if (count_reg == CNTW'(MAX_RANGES))
                            begin
                                res_next.table_full = 1'b1;
                            end
                            else
                            begin
                                wr_do          = 1'b1;
                                count_next     = count_reg + CNTW'(1);
                                res_next.added = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.hit         = out_reg.hit;
    assign rsp.next_value  = out_reg.next_value;
    assign rsp.next_found  = out_reg.next_found;
    assign rsp.first_value = out_reg.first_value;
    assign rsp.first_found = out_reg.first_found;
    assign rsp.added       = out_reg.added;
    assign rsp.table_full  = out_reg.table_full;

    `RSF_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNTW'(MAX_RANGES))
    `RSF_ASSERT_IMPL(a_single_token, clk, rst_n, 1'b1, $onehot0(tok_vld_vec))
    `RSF_ASSERT_IMPL(a_accept_row_empty, clk, rst_n, accept, tok_vld_vec == '0)
    `RSF_ASSERT_IMPL(a_add_flags, clk, rst_n, out_vld_reg, !(out_reg.added && out_reg.table_full))
    `RSF_ASSERT_NEXT(a_write_grows, clk, rst_n, wr_do, count_reg == $past(count_reg) + CNTW'(1))

endmodule

// ===== bench/range_set_filter_core_tb.sv =====
// Self-checking bench for range_set_filter_core: directed table, then random request traffic.
module range_set_filter_core_tb import rsf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_REQS  = 1000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int CALM_FROM    = 500;
    localparam int CALM_TO      = 650;
    localparam int PAUSE_AT     = 750;
    localparam int DRAIN_CYCLES = 2 * MAX_RANGES + 16;

    typedef enum int {ZONE_WIDE, ZONE_LOW, ZONE_HIGH, ZONE_MIXED} value_zone_t;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [31:0] range_end;
        bit          spelled;
        rsf_result_t result;
    } dir_row_t;

    logic clk;
    logic rst_n;

    rsf_req_if req_bus ();
    rsf_rsp_if rsp_bus ();

    range_set_filter_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // shadow copy of the range table
    logic [31:0] set_lo [MAX_RANGES];
    logic [31:0] set_hi [MAX_RANGES];
    int unsigned set_cnt;

    rsf_result_t pending_results [$];
    dir_row_t    dir_rows [$];

    int n_accepted;
    int n_fail;
    int n_appended;
    int n_dropped;
    int n_hits;
    int n_clears;
    int n_queries;
    bit calm;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #400_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic rsf_result_t apply_request(input logic [1:0] kind,
                                                  input logic [31:0] v,
                                                  input logic [31:0] w);
        rsf_result_t r;
        longint lo;
        longint hi;
        longint es;
        longint ee;
        bit moved;
        bit has;
        logic [31:0] ent_lo;
        logic [31:0] ent_hi;
        logic [31:0] cand;
        r = '0;
        case (kind)
            REQ_CLEAR: set_cnt = 0;
            REQ_ADD:
            begin
                if (v <= w)
                begin
                    lo = {32'd0, v};
                    hi = {32'd0, w};
                    moved = 1'b1;
                    // repeat until neither end lands in any stored range
                    while (moved && lo <= hi)
                    begin
                        moved = 1'b0;
                        for (int k = 0; k < set_cnt && lo <= hi; k++)
                        begin
                            es = {32'd0, set_lo[k]};
                            ee = {32'd0, set_hi[k]};
                            if (es <= lo && lo <= ee)
                            begin
                                lo = ee + 1;
                                moved = 1'b1;
                            end
                            if (es <= hi && hi <= ee)
                            begin
                                hi = es - 1;
                                moved = 1'b1;
                            end
                        end
                    end
                    if (lo <= hi)
                    begin
                        if (set_cnt >= MAX_RANGES)
                            r.table_full = 1'b1;
                        else
                        begin
                            set_lo[set_cnt] = lo[31:0];
                            set_hi[set_cnt] = hi[31:0];
                            set_cnt++;
                            r.added = 1'b1;
                        end
                    end
                end
            end
            REQ_QUERY:
            begin
                for (int k = 0; k < set_cnt; k++)
                begin
                    ent_lo = set_lo[k];
                    ent_hi = set_hi[k];
                    if (ent_lo <= v && v <= ent_hi)
                        r.hit = 1'b1;
                    has = 1'b1;
                    cand = '0;
                    if (v < ent_lo)
                        cand = ent_lo;
                    else if (v < ent_hi)
                        cand = v + 32'd1;
                    else
                        has = 1'b0;
                    if (has && (!r.next_found || cand < r.next_value))
                    begin
                        r.next_value = cand;
                        r.next_found = 1'b1;
                    end
                    if (k == 0 || ent_lo < r.first_value)
                        r.first_value = ent_lo;
                end
                r.first_found = (set_cnt != 0);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic rsf_result_t spelled_result(input bit hit, input logic [31:0] nxt,
                                                   input bit nxt_ok, input logic [31:0] first,
                                                   input bit first_ok, input bit added,
                                                   input bit full);
        rsf_result_t r;
        r.hit         = hit;
        r.next_value  = nxt;
        r.next_found  = nxt_ok;
        r.first_value = first;
        r.first_found = first_ok;
        r.added       = added;
        r.table_full  = full;
        return r;
    endfunction

    function automatic void dir_row(input logic [1:0] kind, input logic [31:0] v,
                                    input logic [31:0] w, input bit spelled,
                                    input rsf_result_t res);
        dir_row_t row;
        row.kind      = kind;
        row.value     = v;
        row.range_end = w;
        row.spelled   = spelled;
        row.result    = res;
        dir_rows.push_back(row);
    endfunction

    // values cluster around stored bounds often, so trims and hits are common
    function automatic logic [31:0] pick_value(input value_zone_t zone);
        value_zone_t z;
        int unsigned idx;
        logic [31:0] base;
        if (set_cnt != 0 && $urandom_range(0, 99) < 40)
        begin
            idx = $urandom_range(0, set_cnt - 1);
            base = $urandom_range(0, 1) ? set_lo[idx] : set_hi[idx];
            return base + 32'($urandom_range(0, 2)) - 32'd1;
        end
        z = zone;
        if (z == ZONE_MIXED)
            z = value_zone_t'($urandom_range(0, 2));
        case (z)
            ZONE_LOW:  return 32'($urandom_range(0, 4095));
            ZONE_HIGH: return 32'hFFFF_F000 | 32'($urandom_range(0, 4095));
            default:   return $urandom;
        endcase
    endfunction

    task automatic send_req(input logic [1:0] kind, input logic [31:0] v,
                            input logic [31:0] w, input bit spelled,
                            input rsf_result_t res);
        int gap;
        rsf_result_t want;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 27)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= kind;
        req_bus.value     <= v;
        req_bus.range_end <= w;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        want = apply_request(kind, v, w);
        n_appended += int'(want.added);
        n_dropped  += int'(want.table_full);
        n_hits     += int'(want.hit);
        if (kind == REQ_CLEAR)
            n_clears++;
        if (kind == REQ_QUERY)
            n_queries++;
        pending_results.push_back(spelled ? res : want);
        n_accepted++;
        calm = (n_accepted >= CALM_FROM && n_accepted < CALM_TO);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    // result side: compare each beat, then pick next ready
    initial
    begin
        rsf_result_t want;
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing outstanding");
                    n_fail++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("hit", 32'(want.hit), 32'(rsp_bus.hit));
                    check_field("next_value", want.next_value, rsp_bus.next_value);
                    check_field("next_found", 32'(want.next_found), 32'(rsp_bus.next_found));
                    check_field("first_value", want.first_value, rsp_bus.first_value);
                    check_field("first_found", 32'(want.first_found),
                                32'(rsp_bus.first_found));
                    check_field("added", 32'(want.added), 32'(rsp_bus.added));
                    check_field("table_full", 32'(want.table_full), 32'(rsp_bus.table_full));
                end
            end
            if (!rst_n)
                rsp_bus.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (!hold_done && n_accepted >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_bus.ready <= 1'b0;
            end
            else if (calm)
                rsp_bus.ready <= 1'b1;
            else
                rsp_bus.ready <= ($urandom_range(0, 99) >= 27);
        end
    end

    initial
    begin
        logic [1:0]  kind;
        logic [31:0] lo_v;
        logic [31:0] hi_v;
        logic [31:0] span;
        logic [31:0] tmp;
        logic [32:0] sum;
        value_zone_t zone;
        int seg_left;
        int pick;

        n_accepted = 0;
        n_fail     = 0;
        n_appended = 0;
        n_dropped  = 0;
        n_hits     = 0;
        n_clears   = 0;
        n_queries  = 0;
        calm       = 1'b0;
        set_cnt    = 0;
        rst_n             <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.req_type  <= REQ_CLEAR;
        req_bus.value     <= '0;
        req_bus.range_end <= '0;

        dir_row(REQ_QUERY, 32'd0, 32'd0, 1'b1, '0);
        dir_row(REQ_ADD, 32'd5, 32'd3, 1'b1, '0);
        dir_row(REQ_ADD, 32'd0, 32'd0, 1'b1,
                spelled_result(1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1, 1'b0));
        dir_row(REQ_ADD, 32'd0, 32'd0, 1'b1, '0);
        dir_row(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                spelled_result(1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1, 1'b0));
        // trims to the values between the two single-value entries
        dir_row(REQ_ADD, 32'd0, 32'hFFFF_FFFF, 1'b1,
                spelled_result(1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1, 1'b0));
        dir_row(REQ_ADD, 32'd0, 32'hFFFF_FFFF, 1'b1, '0);
        dir_row(REQ_QUERY, 32'hFFFF_FFFF, 32'd0, 1'b1,
                spelled_result(1'b1, 32'd0, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0));
        dir_row(REQ_QUERY, 32'd0, 32'hFFFF_FFFF, 1'b1,
                spelled_result(1'b1, 32'd1, 1'b1, 32'd0, 1'b1, 1'b0, 1'b0));
        dir_row(REQ_QUERY, 32'h8000_0000, 32'd0, 1'b0, '0);
        dir_row(REQ_UNUSED, 32'd7, 32'd9, 1'b1, '0);
        dir_row(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0);
        dir_row(REQ_QUERY, 32'h1234_5678, 32'd0, 1'b1, '0);
        dir_row(REQ_ADD, 32'd100, 32'd200, 1'b0, '0);
        dir_row(REQ_ADD, 32'd150, 32'd300, 1'b0, '0);
        dir_row(REQ_ADD, 32'd50, 32'd120, 1'b0, '0);
        // both ends trim through the three entries in turn: nothing left
        dir_row(REQ_ADD, 32'd90, 32'd250, 1'b0, '0);
        dir_row(REQ_ADD, 32'd40, 32'd310, 1'b0, '0);
        dir_row(REQ_QUERY, 32'd99, 32'd0, 1'b0, '0);
        dir_row(REQ_QUERY, 32'd300, 32'd0, 1'b0, '0);
        dir_row(REQ_QUERY, 32'd311, 32'd0, 1'b0, '0);
        dir_row(REQ_QUERY, 32'd39, 32'd0, 1'b0, '0);
        dir_row(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].range_end,
                     dir_rows[i].spelled, dir_rows[i].result);

        // segments open with a clear; long enough that the table often fills
        seg_left = 0;
        zone = ZONE_WIDE;
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if (i == PAUSE_AT)
            begin
                req_bus.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            lo_v = $urandom;
            hi_v = $urandom;
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(40, 250);
                zone = value_zone_t'($urandom_range(0, 3));
                kind = REQ_CLEAR;
            end
            else
            begin
                seg_left--;
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    kind = REQ_CLEAR;
                else if (pick < 4)
                    kind = REQ_UNUSED;
                else if (pick < 52)
                    kind = REQ_ADD;
                else
                    kind = REQ_QUERY;
            end
            if (kind == REQ_ADD)
            begin
                lo_v = pick_value(zone);
                case ($urandom_range(0, 2))
                    0: span = $urandom_range(0, 3);
                    1: span = $urandom_range(0, 255);
                    default: span = (zone == ZONE_WIDE) ? $urandom : $urandom_range(0, 1023);
                endcase
                sum = {1'b0, lo_v} + {1'b0, span};
                hi_v = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                if ($urandom_range(0, 19) == 0)
                begin
                    tmp = lo_v;
                    lo_v = hi_v;
                    hi_v = tmp;
                end
            end
            else if (kind == REQ_QUERY)
                lo_v = pick_value(zone);
            send_req(kind, lo_v, hi_v, 1'b0, '0);
        end

        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests: %0d clears, %0d queries (%0d hits)",
                 n_accepted, n_clears, n_queries, n_hits);
        $display("ranges appended %0d, adds dropped on a full table %0d, check failures %0d",
                 n_appended, n_dropped, n_fail);
        if (n_fail == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rsf_pkg.sv
sv/rsf_req_if.sv
sv/rsf_rsp_if.sv
sv/rsf_cell.sv
sv/range_set_filter_core.sv
bench/range_set_filter_core_tb.sv
